>>> rtl/core/dqr_pkg.sv
// Shared constants, types and helpers for the circular deque.
package dqr_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int CAP_W      = 5;
	localparam int REQ_W      = 2;
	localparam int STAT_W     = 2;
	localparam int VAL_W      = 32;
	localparam int OCC_W      = 5;

	localparam logic [REQ_W-1:0] REQ_PUSH_REAR  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 2'd1;
	localparam logic [REQ_W-1:0] REQ_POP_REAR   = 2'd2;
	localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 2'd3;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	// Control from the pointer unit to the store and result stage.
	typedef struct packed {
		logic                 wr_en;
		logic [IDX_W-1:0]     wr_addr;
		logic                 rd_en;
		logic [IDX_W-1:0]     rd_addr;
		logic [STAT_W-1:0]    status;
		logic [CNT_W-1:0]     count;
	} ptr_op_t;

	// Clamp a written capacity to 1..DEPTH.
	function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
		logic [CNT_W-1:0] res;
		if (cap == '0) begin
			res = CNT_W'(1);
		end else if (int'(cap) > DEPTH) begin
			res = CNT_W'(DEPTH);
		end else begin
			res = CNT_W'(cap);
		end
		return res;
	endfunction

endpackage

>>> rtl/core/double_ended_queue_ring.sv
// Top level of the circular double-ended queue.
//
// Usage:
//   Requests enter on in_valid/in_stall with req_type (push rear, push front,
//   pop rear, pop front) and push_value. Every request gives one result on
//   out_valid/out_stall: status (ok, full, empty), pop_value with pop_valid,
//   and the occupancy after the request. The capacity register (1..16, 0
//   reads as 1, larger values clamp to 16) is written over cfg_valid/cfg_ready
//   with cfg_data; cfg_ready is always high. A write empties the deque. Write
//   it only while no request is in flight.
// Timing:
//   One request per cycle sustained while out_stall is low. A result passes
//   through the read stage, which loads with the store read at the accepting
//   edge, and then the output register. Pointers update at the
//   accepting edge and a write lands before the next read, so back-to-back
//   requests need no forwarding.
// Reset:
//   arst_n empties the deque and sets capacity to 16; slot contents stay.
// Backpressure:
//   While out_stall holds a full output register, the read stage keeps its
//   item and in_stall rises once that stage is occupied too.
module double_ended_queue_ring (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [dqr_pkg::CAP_W-1:0]        cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [dqr_pkg::REQ_W-1:0]        req_type,
	input  logic signed [dqr_pkg::VAL_W-1:0] push_value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [dqr_pkg::STAT_W-1:0]       status,
	output logic signed [dqr_pkg::VAL_W-1:0] pop_value,
	output logic                             pop_valid,
	output logic [dqr_pkg::OCC_W-1:0]        occupancy
);

	localparam int DW = dqr_pkg::DATA_WIDTH;

	dqr_pkg::ptr_op_t op;

	logic                           accept;
	logic                           s1_move;
	logic [DW-1:0]                  rd_data;
	logic [DW-1:0]                  wr_data;

	logic                           valid_s1;
	logic [dqr_pkg::STAT_W-1:0]     status_s1;
	logic                           pop_s1;
	logic [dqr_pkg::CNT_W-1:0]      count_s1;

	assign cfg_ready = 1'b1;

	// Advance the read stage when the output register is free or being taken.
	assign s1_move  = !(out_valid && out_stall);
	assign in_stall = valid_s1 && !s1_move;
	assign accept   = in_valid && !in_stall;

	// Keep pushed values to the store width.
	assign wr_data = DW'(push_value);

	dqr_ptr u_ptr (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.accept   (accept),
		.req_type (req_type),
		.op       (op)
	);

	dqr_ram #(
		.DEPTH_P (dqr_pkg::DEPTH),
		.WIDTH_P (DW)
	) u_ram (
		.clk     (clk),
		.wr_en   (op.wr_en),
		.wr_addr (op.wr_addr),
		.wr_data (wr_data),
		.rd_en   (op.rd_en),
		.rd_addr (op.rd_addr),
		.rd_data (rd_data)
	);

	// Read stage: hold the result beside the store read that is under way.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= op.status;
			pop_s1    <= op.rd_en;
			count_s1  <= op.count;
		end
	end

	// Output register: drop the stale read data on anything but a pop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s1_move) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && valid_s1) begin
			status    <= status_s1;
			pop_valid <= pop_s1;
			pop_value <= pop_s1 ? dqr_pkg::VAL_W'(rd_data) : '0;
			occupancy <= dqr_pkg::OCC_W'(count_s1);
		end
	end

	// A popped value is only reported with an ok status.
	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pop_valid |-> status == dqr_pkg::STAT_OK)
		else $error("pop_valid with non-ok status");

	// Occupancy never exceeds the store depth.
	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> int'(occupancy) <= dqr_pkg::DEPTH)
		else $error("occupancy above depth");

	// An accepted request always lands in the read stage.
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted request lost");

	// The store never writes and reads in the same cycle.
	a_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(op.wr_en && op.rd_en))
		else $error("store read and write together");

endmodule

>>> rtl/core/dqr_ram.sv
// Single-port-write, registered-read slot store.
module dqr_ram #(
	parameter int DEPTH_P = 16,
	parameter int WIDTH_P = 32
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [$clog2(DEPTH_P)-1:0] wr_addr,
	input  logic [WIDTH_P-1:0]         wr_data,
	input  logic                       rd_en,
	input  logic [$clog2(DEPTH_P)-1:0] rd_addr,
	output logic [WIDTH_P-1:0]         rd_data
);

	logic [WIDTH_P-1:0] mem [DEPTH_P];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/core/dqr_ptr.sv
// Front/rear pointer, fill count and capacity register of the deque.
module dqr_ptr (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [dqr_pkg::CAP_W-1:0]     cfg_data,
	input  logic                          accept,
	input  logic [dqr_pkg::REQ_W-1:0]     req_type,
	output dqr_pkg::ptr_op_t              op
);

	localparam int IW = dqr_pkg::IDX_W;
	localparam int CW = dqr_pkg::CNT_W;

	logic [CW-1:0] cap_q;
	logic [IW-1:0] front_q;
	logic [IW-1:0] rear_q;
	logic [CW-1:0] count_q;

	logic [IW-1:0] front_d;
	logic [IW-1:0] rear_d;
	logic [CW-1:0] count_d;

	function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] i,
			input logic [CW-1:0] cap);
		logic [CW-1:0] nxt;
		nxt = CW'(i) + CW'(1);
		return (nxt >= cap) ? '0 : IW'(nxt);
	endfunction

	function automatic logic [IW-1:0] wrap_dec(input logic [IW-1:0] i,
			input logic [CW-1:0] cap);
		logic [CW-1:0] cm1;
		cm1 = cap - CW'(1);
		return (i == '0 || CW'(i) >= cap) ? IW'(cm1) : i - IW'(1);
	endfunction

	always_comb begin
		front_d   = front_q;
		rear_d    = rear_q;
		count_d   = count_q;
		op        = '0;
		op.status = dqr_pkg::STAT_OK;
		case (req_type)
			dqr_pkg::REQ_PUSH_REAR: begin
				if (count_q >= cap_q) begin
					op.status = dqr_pkg::STAT_FULL;
				end else begin
					op.wr_en   = 1'b1;
					op.wr_addr = rear_q;
					rear_d     = wrap_inc(rear_q, cap_q);
					count_d    = count_q + CW'(1);
				end
			end
			dqr_pkg::REQ_PUSH_FRONT: begin
				if (count_q >= cap_q) begin
					op.status = dqr_pkg::STAT_FULL;
				end else begin
					front_d    = wrap_dec(front_q, cap_q);
					op.wr_en   = 1'b1;
					op.wr_addr = front_d;
					count_d    = count_q + CW'(1);
				end
			end
			dqr_pkg::REQ_POP_REAR: begin
				if (count_q == '0) begin
					op.status = dqr_pkg::STAT_EMPTY;
				end else begin
					rear_d     = wrap_dec(rear_q, cap_q);
					op.rd_en   = 1'b1;
					op.rd_addr = rear_d;
					count_d    = count_q - CW'(1);
				end
			end
			default: begin
				if (count_q == '0) begin
					op.status = dqr_pkg::STAT_EMPTY;
				end else begin
					op.rd_en   = 1'b1;
					op.rd_addr = front_q;
					front_d    = wrap_inc(front_q, cap_q);
					count_d    = count_q - CW'(1);
				end
			end
		endcase
		op.count = count_d;
		op.wr_en = op.wr_en & accept;
		op.rd_en = op.rd_en & accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= dqr_pkg::eff_cap(dqr_pkg::CAP_RESET);
			front_q <= '0;
			rear_q  <= '0;
			count_q <= '0;
		end else if (cfg_we) begin
			cap_q   <= dqr_pkg::eff_cap(cfg_data);
			front_q <= '0;
			rear_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			front_q <= front_d;
			rear_q  <= rear_d;
			count_q <= count_d;
		end
	end

endmodule
